// File: rtl/core/hsgi_pkg.sv
// Shared types, code ranges, reciprocal constants and variant tables for the
// Hangul syllable glyph index pipeline. No dependencies.
`timescale 1ns / 1ps

package hsgi_pkg;

   localparam logic [15:0] SYL_FIRST = 16'hAC00;
   localparam logic [15:0] SYL_LAST  = 16'hD7AF;
   localparam logic [15:0] CJ_FIRST  = 16'h3131;
   localparam logic [15:0] CJ_LAST   = 16'h314E;

   localparam logic [8:0] MEDIAL_BASE = 9'd160;
   localparam logic [8:0] FINAL_BASE  = 9'd248;
   localparam logic [8:0] CJ_BASE     = 9'd60;

   localparam int IDX_W    = 14;
   localparam int GLYPH_W  = 9;
   localparam int JAMO_W   = 5;

   // floor(x / 7) = (x * RECIP7) >> RECIP7_SHIFT for x < 2796
   localparam logic [11:0] RECIP7       = 12'd2341;
   localparam int          RECIP7_SHIFT = 14;
   // floor(q / 21) = (q * RECIP21) >> RECIP21_SHIFT for q < 400
   localparam logic [11:0] RECIP21       = 12'd3121;
   localparam int          RECIP21_SHIFT = 16;

   typedef enum logic [1:0] {
      KIND_SYLLABLE    = 2'd0,
      KIND_CONSONANT   = 2'd1,
      KIND_UNSUPPORTED = 2'd2
   } kind_type;

   localparam logic [2:0] INIT_ROW_OPEN [22] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
      3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0};
   localparam logic [2:0] INIT_ROW_CLOSED [22] = '{
      3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7,
      3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5};
   localparam logic [1:0] FINAL_ROW [22] = '{
      2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
      2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1};
   localparam logic [4:0] CJ_MAP [30] = '{
      5'd1,  5'd2,  5'd0,  5'd3,  5'd0,  5'd0,  5'd4,  5'd5,  5'd6,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd7,  5'd8,  5'd9,  5'd0,
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19};

   typedef struct packed {
      kind_type            kind;
      logic [JAMO_W-1:0]   lead0;
      logic [JAMO_W-1:0]   vowel0;
      logic [JAMO_W-1:0]   tail;
      logic [GLYPH_W-1:0]  cj_glyph;
   } parts_type;

   typedef struct packed {
      kind_type            kind;
      logic [1:0]          count;
      logic [GLYPH_W-1:0]  initial_glyph;
      logic [GLYPH_W-1:0]  medial_glyph;
      logic [GLYPH_W-1:0]  final_glyph;
   } glyph_type;

endpackage

// File: rtl/core/hsgi_glyph_map.sv
// Maps split jamo parts to the three font layer indices through the variant
// row tables. Depends on hsgi_pkg.
`timescale 1ns / 1ps

module hsgi_glyph_map (
   input  hsgi_pkg::parts_type parts,
   output hsgi_pkg::glyph_type glyph
);

   logic [4:0] vowel;
   logic [4:0] lead;
   logic       closed;
   logic [2:0] irow;
   logic [1:0] vrow;
   logic [1:0] frow;
   logic [8:0] syl_g0;
   logic [8:0] syl_g1;
   logic [8:0] syl_g2;

   always_comb begin
      vowel  = parts.vowel0 + 5'd1;
      lead   = parts.lead0 + 5'd1;
      closed = (parts.tail != 5'd0);
      irow   = closed ? hsgi_pkg::INIT_ROW_CLOSED[vowel] : hsgi_pkg::INIT_ROW_OPEN[vowel];
      vrow   = {closed, !((parts.lead0 == 5'd0) || (parts.lead0 == 5'd15))};
      frow   = hsgi_pkg::FINAL_ROW[vowel];
      syl_g0 = 9'({irow, 4'b0}) + 9'({irow, 2'b0}) + 9'(lead);
      syl_g1 = hsgi_pkg::MEDIAL_BASE + 9'({vrow, 4'b0}) + 9'({vrow, 2'b0})
             + 9'({vrow, 1'b0}) + 9'(vowel);
      syl_g2 = closed ? (hsgi_pkg::FINAL_BASE + 9'({frow, 5'b0}) - 9'({frow, 2'b0})
                         + 9'(parts.tail)) : 9'd0;
   end

   always_comb begin
      glyph = '0;
      unique case (parts.kind)
         hsgi_pkg::KIND_SYLLABLE: begin
            glyph.kind          = hsgi_pkg::KIND_SYLLABLE;
            glyph.count         = closed ? 2'd3 : 2'd2;
            glyph.initial_glyph = syl_g0;
            glyph.medial_glyph  = syl_g1;
            glyph.final_glyph   = syl_g2;
         end
         hsgi_pkg::KIND_CONSONANT: begin
            glyph.kind          = hsgi_pkg::KIND_CONSONANT;
            glyph.count         = 2'd1;
            glyph.initial_glyph = parts.cj_glyph;
         end
         default: begin
            glyph.kind = hsgi_pkg::KIND_UNSUPPORTED;
         end
      endcase
   end

endmodule

// File: rtl/core/hangul_syllable_glyph_index.sv
// Top level of the Hangul syllable glyph index pipeline: classify, divide by
// 28 and 21, table lookup. Depends on hsgi_pkg and hsgi_glyph_map.
`timescale 1ns / 1ps

// Usage:
//   req_ channel carries one 16-bit code point per transaction; rsp_ channel
//   returns kind, layer count and up to three font indices per transaction.
//   A transaction moves at a rising edge with valid high and stall low.
//   From acceptance to rsp_valid a code point passes through four register
//   stages (classify and offset, divide by 28, split by 21 and remainder,
//   table lookup into the output register).
//   Throughput: one transaction per cycle; each stage holds one item and a
//   new code point enters every cycle while the output is taken.
//   Stall: when rsp_stall holds the output, the result stays put and the
//   stages behind it keep filling empty slots; req_stall rises only once
//   every stage holds an item.
//   Reset clears all stage valid bits; the pipeline is empty afterwards and
//   takes a code point once reset is released.
module hangul_syllable_glyph_index (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_char_kind,
   output logic [1:0]  rsp_glyph_count,
   output logic [8:0]  rsp_initial_glyph,
   output logic [8:0]  rsp_medial_glyph,
   output logic [8:0]  rsp_final_glyph
);

   logic [3:0] valid_ff;
   logic [3:0] adv;

   hsgi_pkg::kind_type                   s1_kind_ff, s1_kind_in;
   logic [hsgi_pkg::IDX_W-1:0]           s1_idx_ff, s1_idx_in;
   logic [hsgi_pkg::GLYPH_W-1:0]         s1_cj_ff, s1_cj_in;

   hsgi_pkg::kind_type                   s2_kind_ff;
   logic [hsgi_pkg::IDX_W-1:0]           s2_idx_ff;
   logic [hsgi_pkg::GLYPH_W-1:0]         s2_cj_ff;
   logic [8:0]                           s2_q28_ff, s2_q28_in;
   logic [23:0]                          q7_prod;

   hsgi_pkg::parts_type                  s3_parts_ff, s3_parts_in;
   logic [13:0]                          q28_x28;
   logic [20:0]                          q21_prod;
   logic [4:0]                           lead0;
   logic [8:0]                           lead0_x21;

   hsgi_pkg::glyph_type                  s4_glyph_ff, s4_glyph_in;

   logic [4:0]                           cj_off;

   // advance a stage when it is empty or the stage ahead advances
   always_comb begin
      adv[3] = !valid_ff[3] || !rsp_stall;
      adv[2] = !valid_ff[2] || adv[3];
      adv[1] = !valid_ff[1] || adv[2];
      adv[0] = !valid_ff[0] || adv[1];
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
         if (adv[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   // stage 1: classify, syllable offset, consonant glyph
   always_comb begin
      cj_off     = 5'(req_code_point - hsgi_pkg::CJ_FIRST);
      s1_kind_in = hsgi_pkg::KIND_UNSUPPORTED;
      s1_idx_in  = '0;
      s1_cj_in   = '0;
      if (req_code_point >= hsgi_pkg::SYL_FIRST && req_code_point <= hsgi_pkg::SYL_LAST) begin
         s1_kind_in = hsgi_pkg::KIND_SYLLABLE;
         s1_idx_in  = 14'(req_code_point - hsgi_pkg::SYL_FIRST);
      end else if (req_code_point >= hsgi_pkg::CJ_FIRST
                   && req_code_point <= hsgi_pkg::CJ_LAST) begin
         s1_kind_in = hsgi_pkg::KIND_CONSONANT;
         s1_cj_in   = 9'(hsgi_pkg::CJ_MAP[cj_off]) + hsgi_pkg::CJ_BASE;
      end
   end

   // stage 2: divide by 28 as a shift and a reciprocal multiply by 1/7
   always_comb begin
      q7_prod   = s1_idx_ff[13:2] * hsgi_pkg::RECIP7;
      s2_q28_in = q7_prod[hsgi_pkg::RECIP7_SHIFT +: 9];
   end

   // stage 3: remainder by 28, quotient and remainder by 21
   always_comb begin
      q28_x28   = {s2_q28_ff, 5'b0} - 14'({s2_q28_ff, 2'b0});
      q21_prod  = s2_q28_ff * hsgi_pkg::RECIP21;
      lead0     = q21_prod[hsgi_pkg::RECIP21_SHIFT +: 5];
      lead0_x21 = 9'({lead0, 4'b0}) + 9'({lead0, 2'b0}) + 9'(lead0);
      s3_parts_in.kind     = s2_kind_ff;
      s3_parts_in.lead0    = lead0;
      s3_parts_in.vowel0   = 5'(s2_q28_ff - lead0_x21);
      s3_parts_in.tail     = 5'(s2_idx_ff - q28_x28);
      s3_parts_in.cj_glyph = s2_cj_ff;
   end

   // stage 4: variant tables into the output register
   hsgi_glyph_map u_glyph_map (
      .parts (s3_parts_ff),
      .glyph (s4_glyph_in)
   );

   always_ff @(posedge clock) begin
      if (adv[0] && req_valid) begin
         s1_kind_ff <= s1_kind_in;
         s1_idx_ff  <= s1_idx_in;
         s1_cj_ff   <= s1_cj_in;
      end
      if (adv[1] && valid_ff[0]) begin
         s2_kind_ff <= s1_kind_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_cj_ff   <= s1_cj_ff;
         s2_q28_ff  <= s2_q28_in;
      end
      if (adv[2] && valid_ff[1]) begin
         s3_parts_ff <= s3_parts_in;
      end
      if (adv[3] && valid_ff[2]) begin
         s4_glyph_ff <= s4_glyph_in;
      end
   end

   assign rsp_valid         = valid_ff[3];
   assign rsp_char_kind     = s4_glyph_ff.kind;
   assign rsp_glyph_count   = s4_glyph_ff.count;
   assign rsp_initial_glyph = s4_glyph_ff.initial_glyph;
   assign rsp_medial_glyph  = s4_glyph_ff.medial_glyph;
   assign rsp_final_glyph   = s4_glyph_ff.final_glyph;

   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_initial_glyph < 9'd360) && (rsp_medial_glyph < 9'd360)
                    && (rsp_final_glyph < 9'd360))
      else $error("glyph index out of font range");

   a_unsupported_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_kind == hsgi_pkg::KIND_UNSUPPORTED) |->
         (rsp_glyph_count == 2'd0) && (rsp_initial_glyph == 9'd0)
         && (rsp_medial_glyph == 9'd0) && (rsp_final_glyph == 9'd0))
      else $error("unsupported code with nonzero glyph fields");

   a_syllable_layers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_kind == hsgi_pkg::KIND_SYLLABLE) |->
         ((rsp_glyph_count == 2'd2) && (rsp_final_glyph == 9'd0))
         || ((rsp_glyph_count == 2'd3) && (rsp_final_glyph >= hsgi_pkg::FINAL_BASE)))
      else $error("syllable layer count does not match final layer");

   a_full_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && rsp_stall |-> req_stall)
      else $error("input taken while every stage is held");

endmodule
